FILE: sv/cmpu_pkg.sv
package cmpu_pkg;

    // CORDIC step count and the number of steps actually run (at most one per table entry).
    localparam int CORDIC_STEPS = 24;
    localparam int ITERS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [4:0] ITER_LAST = 5'(ITERS - 1);

    // Inverse CORDIC gain in Q1.30 and the guard bits kept through the rotation.
    localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;
    localparam int GUARD_BITS = 8;
    localparam int SCALE_SHIFT = 30 - GUARD_BITS;

    // Working widths of the rotation datapath.
    localparam int OFS_W = 33;
    localparam int VEC_W = 44;
    localparam int ANG_W = 33;

    // Configuration register indexes.
    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_RATE     = 2'd2;
    localparam logic [1:0] REG_RUNNING  = 2'd3;

    // Item kinds.
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_pos;
        logic       capture;
        logic       angle_en;
        logic       scale_en;
        logic       fold_en;
        logic       iter_en;
        logic       finish_en;
        logic       out_load;
        logic [4:0] step;
    } cmpu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic running;
        logic zero_radius;
    } cmpu_status_t;

    // Arctangent of 2^-i in 2^-32 turn units, rounded to nearest.
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/cmpu_ctrl.sv
module cmpu_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  cmpu_pkg::cmpu_status_t status,
    output cmpu_pkg::cmpu_cmd_t   cmd
);
    import cmpu_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ANGLE  = 3'd1;
    localparam logic [2:0] ST_SCALE  = 3'd2;
    localparam logic [2:0] ST_FOLD   = 3'd3;
    localparam logic [2:0] ST_ITER   = 3'd4;
    localparam logic [2:0] ST_FINISH = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Sequencer: one shared shift-add step per cycle in the iterate state.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.step       = cnt_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    if (action == ACT_LOAD)
                    begin
                        cmd.load_pos = 1'b1;
                        state_next   = ST_OUT;
                    end
                    else if (!status.running || status.zero_radius)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_ANGLE;
                    end
                end
            end
            ST_ANGLE:
            begin
                cmd.angle_en = 1'b1;
                state_next   = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale_en = 1'b1;
                state_next   = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold_en = 1'b1;
                cnt_next    = 5'd0;
                state_next  = ST_ITER;
            end
            ST_ITER:
            begin
                cmd.iter_en = 1'b1;
                cnt_next    = cnt_reg + 5'd1;
                if (cnt_reg == ITER_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish_en = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/cmpu_datapath.sv
module cmpu_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic [23:0]           elapsed_us,
    input  logic signed [31:0]    new_x,
    input  logic signed [31:0]    new_y,
    input  logic signed [31:0]    new_z,
    input  cmpu_pkg::cmpu_cmd_t   cmd,
    output cmpu_pkg::cmpu_status_t status,
    output logic signed [31:0]    pos_x,
    output logic signed [31:0]    pos_y,
    output logic signed [31:0]    pos_z
);
    import cmpu_pkg::*;

    logic signed [31:0]       cx_reg, cy_reg;
    logic [31:0]              rate_reg;
    logic                     run_reg;
    logic signed [31:0]       px_reg, py_reg, pz_reg;
    logic [23:0]              el_reg;
    logic signed [OFS_W-1:0]  dx_reg, dy_reg;
    logic [31:0]              ang_reg;
    logic signed [VEC_W-1:0]  x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic signed [31:0]       ox_reg, oy_reg, oz_reg;

    logic [31:0]              ang_prod;
    logic signed [64:0]       mx, my;
    logic                     flip;
    logic [31:0]              ang_fold;
    logic signed [VEC_W-1:0]  xs, ys;
    logic signed [ANG_W-1:0]  atan_s;
    logic signed [VEC_W-1:0]  xr, yr;
    logic signed [36:0]       sx, sy;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111)
        begin
            r = v[31:0];
        end
        else if (v[36])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    assign status.running     = run_reg;
    assign status.zero_radius = (px_reg == cx_reg) && (py_reg == cy_reg);

    // Angle step, wrapped to one turn by keeping the low 32 bits.
    assign ang_prod = {8'd0, el_reg} * rate_reg;

    // Gain correction products.
    assign mx = 65'(dx_reg) * 65'(INV_GAIN_Q30);
    assign my = 65'(dy_reg) * 65'(INV_GAIN_Q30);

    // Fold the angle into [-1/4, 1/4) turn by a half-turn flip.
    assign flip     = ang_reg[31] ^ ang_reg[30];
    assign ang_fold = {ang_reg[31] ^ flip, ang_reg[30:0]};

    // One CORDIC micro-rotation.
    assign xs     = x_reg >>> cmd.step;
    assign ys     = y_reg >>> cmd.step;
    assign atan_s = $signed({1'b0, atan_turns(cmd.step)});

    // Round off the guard bits and add the center back.
    assign xr = x_reg + VEC_W'(1 << (GUARD_BITS - 1));
    assign yr = y_reg + VEC_W'(1 << (GUARD_BITS - 1));
    assign sx = 37'($signed(xr[VEC_W-1:GUARD_BITS])) + 37'(cx_reg);
    assign sy = 37'($signed(yr[VEC_W-1:GUARD_BITS])) + 37'(cy_reg);

    // Configuration and position state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            rate_reg <= '0;
            run_reg  <= 1'b0;
            px_reg   <= '0;
            py_reg   <= '0;
            pz_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CENTER_X: cx_reg   <= cfg_data;
                    REG_CENTER_Y: cy_reg   <= cfg_data;
                    REG_RATE:     rate_reg <= cfg_data;
                    REG_RUNNING:  run_reg  <= cfg_data[0];
                    default:      ;
                endcase
            end
            if (cmd.load_pos)
            begin
                px_reg <= new_x;
                py_reg <= new_y;
                pz_reg <= new_z;
            end
            else if (cmd.finish_en)
            begin
                px_reg <= sat32(sx);
                py_reg <= sat32(sy);
            end
        end
    end

    // Rotation working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            el_reg <= elapsed_us;
        end
        if (cmd.angle_en)
        begin
            ang_reg <= ang_prod;
            dx_reg  <= 33'(px_reg) - 33'(cx_reg);
            dy_reg  <= 33'(py_reg) - 33'(cy_reg);
        end
        if (cmd.scale_en)
        begin
            x_reg <= VEC_W'(mx >>> SCALE_SHIFT);
            y_reg <= VEC_W'(my >>> SCALE_SHIFT);
        end
        if (cmd.fold_en)
        begin
            if (flip)
            begin
                x_reg <= -x_reg;
                y_reg <= -y_reg;
            end
            z_reg <= 33'($signed(ang_fold));
        end
        if (cmd.iter_en)
        begin
            if (!z_reg[ANG_W-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_s;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_s;
            end
        end
        if (cmd.out_load)
        begin
            ox_reg <= px_reg;
            oy_reg <= py_reg;
            oz_reg <= pz_reg;
        end
    end

    assign pos_x = ox_reg;
    assign pos_y = oy_reg;
    assign pos_z = oz_reg;

endmodule

FILE: sv/circular_motion_position_update_core.sv
// Holds a point (x, y, z) in Q16.16 and moves it on a circle around the configured
// center. A tick beat advances time by elapsed_us and, while running, rotates the
// offset from the center by elapsed_us times angular_rate (binary angle, wraps every
// turn) with an iterative CORDIC; a load beat sets the position. Every input beat
// returns exactly one result beat with the new position. A tick that rotates steps
// through the angle, scale, fold, iterate, finish and output states, the iterate
// state using the single shift-add unit that performs one CORDIC step per cycle;
// a load beat, a paused tick or a tick with the point on the center goes straight
// to the output state. One item is in work at a time; the next is taken once the
// result is in the output register. Configuration writes are taken every cycle.
module circular_motion_position_update_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [23:0]        elapsed_us,
    input  logic signed [31:0] new_x,
    input  logic signed [31:0] new_y,
    input  logic signed [31:0] new_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z
);
    import cmpu_pkg::*;

    cmpu_cmd_t    cmd;
    cmpu_status_t status;

    assign cfg_ready = 1'b1;

    // Sequencer.
    cmpu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Registers, multipliers and the CORDIC unit.
    cmpu_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .elapsed_us (elapsed_us),
        .new_x      (new_x),
        .new_y      (new_y),
        .new_z      (new_z),
        .cmd        (cmd),
        .status     (status),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z)
    );

endmodule

FILE: sv/cmpu_checker.sv
module cmpu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               action,
    input logic signed [31:0] new_x,
    input logic signed [31:0] new_z,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] pos_x,
    input logic signed [31:0] pos_y,
    input logic signed [31:0] pos_z
);
    import cmpu_pkg::*;

    // A stalled result beat holds its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(pos_z))
        else $error("result beat changed while stalled");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in work");

    // A load beat taken with the output free returns its position through the output register.
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (action == ACT_LOAD) && (!out_valid || out_ready)
            |-> ##2 out_valid && (pos_x == $past(new_x, 2)) && (pos_z == $past(new_z, 2)))
        else $error("load beat did not return the loaded position");

endmodule

bind circular_motion_position_update_core cmpu_checker u_cmpu_checker (.*);
